>>> sv/ikp_pkg.sv
// shared types and constants of the imu kalman predict block
package ikp_pkg;

   localparam int STATE_FRAC_BITS_DEF = 16;

   localparam logic [23:0] DT_RESET = 24'd33554;

   localparam logic [1:0] REG_TIME_STEP      = 2'd0;
   localparam logic [1:0] REG_POSITION_NOISE = 2'd1;
   localparam logic [1:0] REG_VELOCITY_NOISE = 2'd2;
   localparam logic [1:0] REG_GRAVITY        = 2'd3;

   typedef struct packed {
      logic signed [15:0] qw;
      logic signed [15:0] qx;
      logic signed [15:0] qy;
      logic signed [15:0] qz;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
   } item_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [30:0] ppx;
      logic [30:0] ppy;
      logic [30:0] ppz;
      logic [30:0] vvx;
      logic [30:0] vvy;
      logic [30:0] vvz;
   } result_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] x);
      if (x > 72'sd2147483647) return 32'sh7fffffff;
      if (x < -72'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] satvar(input logic signed [71:0] x);
      if (x > 72'sd2147483647) return 32'sh7fffffff;
      if (x < 72'sd0) return 32'sd0;
      return x[31:0];
   endfunction

endpackage

>>> sv/ikp_front.sv
// input queue that buffers accepted samples for the compute engine
module ikp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  ikp_pkg::item_type  item_in,
   output logic               have_item,
   input  logic               take_item,
   output ikp_pkg::item_type  item_out
);

   ikp_pkg::item_type mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign have_item = (count_ff != 2'd0);
   assign item_out  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push && !full) wr_ptr_ff <= !wr_ptr_ff;
         if (take_item && have_item) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'((push && !full) ? 1 : 0)
                     - 2'((take_item && have_item) ? 1 : 0);
      end
   end

endmodule

>>> sv/ikp_back.sv
// sequenced compute engine: rotation, gravity, per axis state and covariance update
module ikp_back #(
   parameter int STATE_FRAC_BITS = ikp_pkg::STATE_FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                have_item,
   output logic                take_item,
   input  ikp_pkg::item_type   item,
   input  logic [23:0]         time_step,
   input  logic [30:0]         position_noise,
   input  logic [30:0]         velocity_noise,
   input  logic [30:0]         gravity,
   output logic                res_valid,
   input  logic                res_ready,
   output ikp_pkg::result_type res
);

   localparam logic signed [31:0] VAR_RESET =
      32'(((64'sd1 << STATE_FRAC_BITS) + 64'sd5) / 64'sd10);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ROT  = 6'b000010,
      S_MAC  = 6'b000100,
      S_AXIS = 6'b001000,
      S_UPD  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type state_ff;
   logic [1:0] row_ff, col_ff;
   ikp_pkg::item_type it_ff;
   logic signed [31:0] r_ff [3][3];
   logic signed [71:0] acc_ff;
   logic signed [31:0] aw_ff [3];
   logic signed [31:0] pos_ff [3], vel_ff [3], pp_ff [3], pv_ff [3], vv_ff [3];
   logic [23:0] dt2_ff;
   logic signed [71:0] t_ff [5];
   ikp_pkg::result_type res_w;

   // wide enough for the matrix entries at 28 fraction bits
   logic signed [35:0] w, x, y, z;
   logic signed [31:0] rsel, asel, awi;
   logic signed [71:0] prod, rowsum;
   logic signed [31:0] dts, hdt2s;

   assign w = 36'(it_ff.qw);
   assign x = 36'(it_ff.qx);
   assign y = 36'(it_ff.qy);
   assign z = 36'(it_ff.qz);
   assign dts   = $signed({8'd0, time_step});
   assign hdt2s = $signed({9'd0, dt2_ff[23:1]});

   always_comb begin
      rsel = r_ff[row_ff][col_ff];
      case (col_ff)
         2'd0:    asel = it_ff.ax;
         2'd1:    asel = it_ff.ay;
         default: asel = it_ff.az;
      endcase
      prod   = 72'(rsel) * 72'(asel);
      rowsum = acc_ff + prod;
      awi    = ikp_pkg::sat32(rowsum >>> 14);
   end

   assign take_item = (state_ff == S_IDLE) && have_item;
   assign res_valid = (state_ff == S_OUT);
   assign res       = res_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
            pp_ff[i]  <= VAR_RESET;
            pv_ff[i]  <= '0;
            vv_ff[i]  <= VAR_RESET;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (have_item) begin
                  it_ff    <= item;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               // matrix entries at 28 fraction bits, then down to 14
               r_ff[0][0] <= 32'(((36'sd1 <<< 28) - 2 * (y * y + z * z)) >>> 14);
               r_ff[0][1] <= 32'((2 * (x * y - w * z)) >>> 14);
               r_ff[0][2] <= 32'((2 * (x * z + w * y)) >>> 14);
               r_ff[1][0] <= 32'((2 * (x * y + w * z)) >>> 14);
               r_ff[1][1] <= 32'(((36'sd1 <<< 28) - 2 * (x * x + z * z)) >>> 14);
               r_ff[1][2] <= 32'((2 * (y * z - w * x)) >>> 14);
               r_ff[2][0] <= 32'((2 * (x * z - w * y)) >>> 14);
               r_ff[2][1] <= 32'((2 * (y * z + w * x)) >>> 14);
               r_ff[2][2] <= 32'(((36'sd1 <<< 28) - 2 * (x * x + y * y)) >>> 14);
               dt2_ff   <= 24'((48'(time_step) * 48'(time_step)) >> 24);
               acc_ff   <= '0;
               row_ff   <= 2'd0;
               col_ff   <= 2'd0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               if (col_ff == 2'd2) begin
                  acc_ff <= '0;
                  col_ff <= 2'd0;
                  if (row_ff == 2'd2) begin
                     aw_ff[2] <= ikp_pkg::sat32(72'(awi) - 72'($signed({1'b0, gravity})));
                     row_ff   <= 2'd0;
                     state_ff <= S_AXIS;
                  end else begin
                     aw_ff[row_ff] <= awi;
                     row_ff        <= row_ff + 2'd1;
                  end
               end else begin
                  acc_ff <= rowsum;
                  col_ff <= col_ff + 2'd1;
               end
            end
            S_AXIS: begin
               t_ff[0] <= (72'(vel_ff[row_ff]) * 72'(dts)) >>> 24;
               t_ff[1] <= (72'(aw_ff[row_ff]) * 72'(hdt2s)) >>> 24;
               t_ff[2] <= (72'(aw_ff[row_ff]) * 72'(dts)) >>> 24;
               t_ff[3] <= (72'(pv_ff[row_ff]) * 72'(dts)) >>> 24;
               t_ff[4] <= (72'(vv_ff[row_ff]) * 72'($signed({8'd0, dt2_ff}))) >>> 24;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               pos_ff[row_ff] <= ikp_pkg::sat32(72'(pos_ff[row_ff]) + t_ff[0] + t_ff[1]);
               vel_ff[row_ff] <= ikp_pkg::sat32(72'(vel_ff[row_ff]) + t_ff[2]);
               pp_ff[row_ff]  <= ikp_pkg::satvar(72'(pp_ff[row_ff]) + 2 * t_ff[3] + t_ff[4]
                                 + 72'($signed({1'b0, position_noise})));
               pv_ff[row_ff]  <= ikp_pkg::sat32(72'(pv_ff[row_ff])
                                 + ((72'(vv_ff[row_ff]) * 72'(dts)) >>> 24));
               vv_ff[row_ff]  <= ikp_pkg::satvar(72'(vv_ff[row_ff])
                                 + 72'($signed({1'b0, velocity_noise})));
               if (row_ff == 2'd2) begin
                  row_ff   <= 2'd0;
                  state_ff <= S_OUT;
               end else begin
                  row_ff   <= row_ff + 2'd1;
                  state_ff <= S_AXIS;
               end
            end
            S_OUT: begin
               if (res_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      res_w.px  = pos_ff[0];
      res_w.py  = pos_ff[1];
      res_w.pz  = pos_ff[2];
      res_w.vx  = vel_ff[0];
      res_w.vy  = vel_ff[1];
      res_w.vz  = vel_ff[2];
      res_w.ppx = pp_ff[0][30:0];
      res_w.ppy = pp_ff[1][30:0];
      res_w.ppz = pp_ff[2][30:0];
      res_w.vvx = vv_ff[0][30:0];
      res_w.vvy = vv_ff[1][30:0];
      res_w.vvz = vv_ff[2][30:0];
   end

endmodule

>>> sv/ikp_out.sv
// one entry result register between the engine and the result channel
module ikp_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                res_valid,
   output logic                res_ready,
   input  ikp_pkg::result_type res_in,
   output logic                empty,
   input  logic                pop,
   output ikp_pkg::result_type res_out
);

   logic valid_ff;
   ikp_pkg::result_type data_ff;

   assign res_ready = !valid_ff;
   assign empty     = !valid_ff;
   assign res_out   = data_ff;

   always_ff @(posedge clock) begin
      if (res_valid && !valid_ff) data_ff <= res_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_valid && !valid_ff) begin
         valid_ff <= 1'b1;
      end else if (pop && valid_ff) begin
         valid_ff <= 1'b0;
      end
   end

endmodule

>>> sv/imu_kalman_predict.sv
// top level of the imu kalman predict block
// usage:
// - samples (quaternion q2.14, body acceleration q16.16) enter as a queue:
//   a transfer happens when push is high and full is low
// - results (position, velocity, diagonal variances) leave as a queue:
//   a result waits while empty is low and is taken when pop is high
// - csr channel writes time_step, position_noise, velocity_noise, gravity by
//   index on csr_valid and csr_ready; write only while the block is idle
// - each sample passes through the engine in steps: one to take it, one for the
//   rotation matrix, nine multiply-accumulate steps on the shared multiplier,
//   two per axis for the state and covariance update, one to hand it over
// - a two entry input queue lets new samples in while the engine works
// - when the receiver stalls the result register holds, the engine waits,
//   then the input queue fills and full rises
// - synchronous reset restores register defaults, clears state and the
//   queues; variances return to 0.1
module imu_kalman_predict #(
   parameter int STATE_FRAC_BITS = ikp_pkg::STATE_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [31:0] req_accel_x,
   input  logic signed [31:0] req_accel_y,
   input  logic signed [31:0] req_accel_z,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_pos_z,
   output logic signed [31:0] rsp_vel_x,
   output logic signed [31:0] rsp_vel_y,
   output logic signed [31:0] rsp_vel_z,
   output logic [30:0]        rsp_pos_var_x,
   output logic [30:0]        rsp_pos_var_y,
   output logic [30:0]        rsp_pos_var_z,
   output logic [30:0]        rsp_vel_var_x,
   output logic [30:0]        rsp_vel_var_y,
   output logic [30:0]        rsp_vel_var_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [30:0] QP_RESET =
      31'(((64'sd1 << STATE_FRAC_BITS) + 64'sd500) / 64'sd1000);
   localparam logic [30:0] QV_RESET =
      31'(((64'sd1 << STATE_FRAC_BITS) + 64'sd50) / 64'sd100);
   localparam logic [30:0] GRAV_RESET =
      31'((64'sd981 * (64'sd1 << STATE_FRAC_BITS) + 64'sd50) / 64'sd100);

   logic [23:0] time_step_ff;
   logic [30:0] position_noise_ff, velocity_noise_ff, gravity_ff;

   ikp_pkg::item_type   item_in, item_q;
   ikp_pkg::result_type res_e, res_o;
   logic have_item, take_item, res_valid, res_ready;

   assign csr_ready = 1'b1;

   // register file, written one transfer at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff      <= ikp_pkg::DT_RESET;
         position_noise_ff <= QP_RESET;
         velocity_noise_ff <= QV_RESET;
         gravity_ff        <= GRAV_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ikp_pkg::REG_TIME_STEP:      time_step_ff      <= csr_wdata[23:0];
            ikp_pkg::REG_POSITION_NOISE: position_noise_ff <= csr_wdata[30:0];
            ikp_pkg::REG_VELOCITY_NOISE: velocity_noise_ff <= csr_wdata[30:0];
            ikp_pkg::REG_GRAVITY:        gravity_ff        <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign item_in = '{qw: req_quat_w, qx: req_quat_x, qy: req_quat_y, qz: req_quat_z,
                      ax: req_accel_x, ay: req_accel_y, az: req_accel_z};

   // front: input queue
   ikp_front u_front (
      .clock, .reset, .push, .full, .item_in,
      .have_item, .take_item, .item_out(item_q)
   );

   // back: compute engine
   ikp_back #(.STATE_FRAC_BITS(STATE_FRAC_BITS)) u_back (
      .clock, .reset, .have_item, .take_item, .item(item_q),
      .time_step(time_step_ff), .position_noise(position_noise_ff),
      .velocity_noise(velocity_noise_ff), .gravity(gravity_ff),
      .res_valid, .res_ready, .res(res_e)
   );

   // result register
   ikp_out u_out (
      .clock, .reset, .res_valid, .res_ready, .res_in(res_e),
      .empty, .pop, .res_out(res_o)
   );

   assign rsp_pos_x     = res_o.px;
   assign rsp_pos_y     = res_o.py;
   assign rsp_pos_z     = res_o.pz;
   assign rsp_vel_x     = res_o.vx;
   assign rsp_vel_y     = res_o.vy;
   assign rsp_vel_z     = res_o.vz;
   assign rsp_pos_var_x = res_o.ppx;
   assign rsp_pos_var_y = res_o.ppy;
   assign rsp_pos_var_z = res_o.ppz;
   assign rsp_vel_var_x = res_o.vvx;
   assign rsp_vel_var_y = res_o.vvy;
   assign rsp_vel_var_z = res_o.vvz;

endmodule
